FILE: sv/imhq_pkg.sv
// Shared sizes, request codes and types for the indexed max-heap queue.
// Used by imhq_cell and indexed_max_heap_queue; depends on nothing.
`default_nettype none

package imhq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int KEY_W    = 4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request operations carried in s_tuser
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } heap_op_t;

    // Result status carried in m_tuser
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4
    } heap_status_t;

    // One heap entry: priority and the key it carries
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [KEY_W-1:0]          key;
    } entry_t;

    // Write request broadcast along the slot row
    typedef struct packed {
        logic   en;
        idx_t   idx;
        entry_t data;
    } wr_bus_t;

endpackage

`default_nettype wire

FILE: sv/imhq_cell.sv
// One heap slot: holds a value/key pair and matches its key against the search key.
// Depends on imhq_pkg.
`default_nettype none

module imhq_cell
    import imhq_pkg::*;
(
    input  wire  logic             aclk,
    input  wire  idx_t             slot_id,
    input  wire  cnt_t             entry_count,
    input  wire  wr_bus_t          wr,
    input  wire  logic [KEY_W-1:0] search_key,
    output       entry_t           slot_q,
    output       logic             key_hit
);

    entry_t entry_reg;
    logic   occupied;

    // Load the entry when the write request names this slot
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.idx == slot_id)) begin
            entry_reg <= wr.data;
        end
    end

    // Only slots below the fill count hold live entries
    assign occupied = cnt_t'(slot_id) < entry_count;
    assign key_hit  = occupied && (entry_reg.key == search_key);
    assign slot_q   = entry_reg;

endmodule

`default_nettype wire

FILE: sv/indexed_max_heap_queue.sv
// Indexed binary max-heap priority queue: sequencer, slot row and result register.
// Depends on imhq_pkg and imhq_cell.
//
//  channel | ports                  | tdata (low bit up)            | tuser
//  --------+------------------------+-------------------------------+-------------
//  command | s_tvalid/s_tready      | prio_value, entry_key, 4'b0   | cmd
//  result  | m_tvalid/m_tready      | out_value, out_key, 4'b0      | status
//
// A request passes through accept, decode, sift steps through the slot row's single
// write port (one heap level per step), and finish; refused requests and a pop of the
// only entry skip the sift.
// aresetn empties the heap at once (fill count to zero); slot contents are not cleared.
// A new request is taken while a finished result still waits in the output register;
// completion stalls only if that register is still occupied.
`default_nettype none

module indexed_max_heap_queue
    import imhq_pkg::*;
(
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        s_tvalid,
    output       logic        s_tready,
    input  wire  logic [39:0] s_tdata,   // prio_value[31:0], entry_key[35:32], zero pad
    input  wire  logic [1:0]  s_tuser,   // cmd[1:0]
    output       logic        m_tvalid,
    input  wire  logic        m_tready,
    output       logic [39:0] m_tdata,   // out_value[31:0], out_key[35:32], zero pad
    output       logic [2:0]  m_tuser    // status[2:0]
);

    localparam int LW = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_DOWN,
        S_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [1:0]                cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    entry_t                    mov_reg, mov_next;
    idx_t                      pos_reg, pos_next;
    cnt_t                      count_reg, count_next;
    logic                      upd_reg, upd_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [KEY_W-1:0]          res_key_reg, res_key_next;
    logic [2:0]                res_status_reg, res_status_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic signed [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [KEY_W-1:0]          m_key_reg, m_key_next;
    logic [2:0]                m_status_reg, m_status_next;

    wr_bus_t               wr;
    entry_t                slot_q [CAPACITY];
    logic [CAPACITY-1:0]   hit;
    logic                  hit_any;
    idx_t                  hit_pos;
    idx_t                  parent_idx;
    idx_t                  last_idx;
    idx_t                  left_idx;
    idx_t                  right_idx;
    idx_t                  pick_idx;
    logic [LW-1:0]         left_ext;
    logic [LW-1:0]         cnt_ext;
    logic                  left_out;
    logic                  left_is_last;
    entry_t                parent_q;
    entry_t                pick_q;
    cnt_t                  count_dec;

    // Row of heap slots sharing one write request and one key search
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        imhq_cell u_cell (
            .aclk        (aclk),
            .slot_id     (idx_t'(g)),
            .entry_count (count_reg),
            .wr          (wr),
            .search_key  (key_reg),
            .slot_q      (slot_q[g]),
            .key_hit     (hit[g])
        );
    end

    // Encode the position of the matching key (at most one slot hits)
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit[i]) begin
                hit_pos = hit_pos | idx_t'(i);
            end
        end
    end
    assign hit_any = |hit;

    // Neighbors of the hole during a sift
    assign count_dec    = count_reg - cnt_t'(1);
    assign last_idx     = count_dec[IDX_W-1:0];
    assign parent_idx   = (pos_reg - idx_t'(1)) >> 1;
    assign left_ext     = LW'({pos_reg, 1'b1});
    assign cnt_ext      = LW'(count_reg);
    assign left_out     = left_ext >= cnt_ext;
    assign left_is_last = left_ext == (cnt_ext - LW'(1));
    assign left_idx     = left_ext[IDX_W-1:0];
    assign right_idx    = left_idx + idx_t'(1);
    assign parent_q     = slot_q[parent_idx];

    // Pick the larger child, the right one on a tie
    always_comb begin
        if (left_is_last || (slot_q[left_idx].value > slot_q[right_idx].value)) begin
            pick_idx = left_idx;
        end else begin
            pick_idx = right_idx;
        end
    end
    assign pick_q = slot_q[pick_idx];

    // Sequencer next state
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        key_next        = key_reg;
        mov_next        = mov_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        upd_next        = upd_reg;
        res_value_next  = res_value_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        m_value_next    = m_value_reg;
        m_key_next      = m_key_reg;
        m_status_next   = m_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        wr.en           = 1'b0;
        wr.idx          = pos_reg;
        wr.data         = mov_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    value_next = s_tdata[VALUE_W-1:0];
                    key_next   = s_tdata[VALUE_W+KEY_W-1:VALUE_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_value_next  = '0;
                res_key_next    = '0;
                res_status_next = ST_OK;
                state_next      = S_FINISH;
                unique case (cmd_reg)
                    OP_PUSH: begin
                        if (count_reg == cnt_t'(CAPACITY)) begin
                            res_status_next = ST_FULL;
                        end else if (hit_any) begin
                            res_status_next = ST_DUP;
                        end else begin
                            mov_next   = '{value: value_reg, key: key_reg};
                            pos_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + cnt_t'(1);
                            upd_next   = 1'b0;
                            state_next = S_UP;
                        end
                    end
                    OP_POP: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_value_next = slot_q[0].value;
                            res_key_next   = slot_q[0].key;
                            mov_next       = slot_q[last_idx];
                            count_next     = count_dec;
                            pos_next       = '0;
                            if (count_dec != '0) begin
                                state_next = S_DOWN;
                            end
                        end
                    end
                    OP_UPDATE: begin
                        if (!hit_any) begin
                            res_status_next = ST_ABSENT;
                        end else begin
                            mov_next   = '{value: value_reg, key: key_reg};
                            pos_next   = hit_pos;
                            upd_next   = 1'b1;
                            state_next = S_UP;
                        end
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_UP: begin
                // Pull a smaller parent down into the hole, else settle here (an update goes on to sift down)
                if ((pos_reg != '0) && (parent_q.value < mov_reg.value)) begin
                    wr.en    = 1'b1;
                    wr.data  = parent_q;
                    pos_next = parent_idx;
                end else if (upd_reg) begin
                    state_next = S_DOWN;
                end else begin
                    wr.en      = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DOWN: begin
                // Pull the larger child up into the hole, else settle here
                if (!left_out && (mov_reg.value < pick_q.value)) begin
                    wr.en    = 1'b1;
                    wr.data  = pick_q;
                    pos_next = pick_idx;
                end else begin
                    wr.en      = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_value_next  = res_value_reg;
                    m_key_next    = res_key_reg;
                    m_status_next = res_status_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        key_reg        <= key_next;
        mov_reg        <= mov_next;
        pos_reg        <= pos_next;
        upd_reg        <= upd_next;
        res_value_reg  <= res_value_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_key_reg      <= m_key_next;
        m_status_reg   <= m_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_key_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(CAPACITY))
        else $error("fill count beyond capacity");

    // The heap is settled at decode; mid-sift the hole may repeat a neighbor's key
    a_key_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE) |-> $onehot0(hit))
        else $error("key held by more than one live slot");

    a_hole_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP || state_reg == S_DOWN) |-> cnt_t'(pos_reg) < count_reg)
        else $error("sift hole outside live entries");

    a_up_climbs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP && $past(state_reg) == S_UP) |-> pos_reg < $past(pos_reg))
        else $error("sift up did not move toward the root");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> m_tdata == '0)
        else $error("refused request carries a nonzero payload");
`endif

endmodule

`default_nettype wire
